FILE: sv/cpc_pkg.sv
// Shared types and constants for the cascaded position/current controller.
package cpc_pkg;

    localparam int GAIN_W     = 24;
    localparam int LIMIT_W    = 8;
    localparam int ERR_W      = 9;
    localparam int MEAS_W     = 8;
    localparam int SP_W       = 8;
    localparam int DUTY_W     = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int POS_SUM_W  = 38;

    localparam logic OP_OUTER = 1'b0;
    localparam logic OP_INNER = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_POS_KP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POS_KI_UP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POS_KI_DOWN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POS_KD      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UP_LIMIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_LIMIT  = 3'd5;

    localparam logic [LIMIT_W-1:0] UP_LIMIT_RST   = 8'd60;
    localparam logic [LIMIT_W-1:0] DOWN_LIMIT_RST = 8'd20;

    // setpoint bands for inner gain scheduling (moving up)
    localparam int SP_BAND_A = 30;
    localparam int SP_BAND_B = 40;
    localparam int SP_BAND_C = 60;
    localparam int SP_BAND_D = 100;

    localparam int DUTY_MAX = 127;
    localparam int DUTY_MIN = 1;

    typedef struct packed {
        logic [GAIN_W-1:0]  kp;
        logic [GAIN_W-1:0]  ki_up;
        logic [GAIN_W-1:0]  ki_down;
        logic [GAIN_W-1:0]  kd;
        logic [LIMIT_W-1:0] up_limit;
        logic [LIMIT_W-1:0] down_limit;
    } pos_cfg_t;

    typedef struct packed {
        logic                    opcode;
        logic signed [ERR_W-1:0] position_error;
        logic                    direction;
        logic [MEAS_W-1:0]       measured_current;
    } item_t;

endpackage

FILE: sv/cascaded_position_current_pid.sv
// Top level: input register, config registers, outer and inner loops, result handshake.
// An accepted input beat waits in the input register; its result then lands in the loop state registers.
// Throughput: one beat per cycle unless stalled; one pass of multiply-add logic per
// step, from the input register into the loop state registers, which double as the
// result register. Reset: async active low; clears both valid flags and loads the
// loop state and config registers with their reset values.
module cascaded_position_current_pid #(
    parameter int GAIN_FRAC_BITS = 20
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 opcode,
    input  logic signed [cpc_pkg::ERR_W-1:0]     position_error,
    input  logic                                 direction,
    input  logic [cpc_pkg::MEAS_W-1:0]           measured_current,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [cpc_pkg::SP_W-1:0]             current_setpoint,
    output logic [cpc_pkg::DUTY_W-1:0]           duty,
    input  logic                                 cfg_we,
    input  logic [cpc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [cpc_pkg::GAIN_W-1:0]           cfg_data
);

    localparam int F    = GAIN_FRAC_BITS;
    localparam int GW   = cpc_pkg::GAIN_W;
    localparam int CG_W = F + 4;

    localparam logic [GW-1:0] KP_RST    = GW'(((64'(1) << F) + 64'(2)) / 64'(5));
    localparam logic [GW-1:0] KI_UP_RST = GW'(64'(1) << F);
    localparam logic [GW-1:0] KI_DN_RST = GW'(((64'(1) << F) + 64'(50)) / 64'(100));
    localparam logic [GW-1:0] KD_RST    = GW'(((64'(133) << F) + 64'(2500)) / 64'(5000));

    cpc_pkg::pos_cfg_t cfg_reg;
    cpc_pkg::item_t    item_reg;
    logic              in_vld_reg;
    logic              out_vld_reg;
    logic              advance;
    logic              outer_en;
    logic              inner_en;
    logic [CG_W-1:0]   cur_kp;
    logic [CG_W-1:0]   cur_ki;

    assign advance  = !out_vld_reg || !out_stall;
    assign in_stall = in_vld_reg && !advance;
    assign outer_en = advance && in_vld_reg && (item_reg.opcode == cpc_pkg::OP_OUTER);
    assign inner_en = advance && in_vld_reg && (item_reg.opcode == cpc_pkg::OP_INNER);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_vld_reg <= in_valid;
            if (advance)
                out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg.opcode           <= opcode;
            item_reg.position_error   <= position_error;
            item_reg.direction        <= direction;
            item_reg.measured_current <= measured_current;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp         <= KP_RST;
            cfg_reg.ki_up      <= KI_UP_RST;
            cfg_reg.ki_down    <= KI_DN_RST;
            cfg_reg.kd         <= KD_RST;
            cfg_reg.up_limit   <= cpc_pkg::UP_LIMIT_RST;
            cfg_reg.down_limit <= cpc_pkg::DOWN_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cpc_pkg::REG_POS_KP:      cfg_reg.kp         <= cfg_data;
                cpc_pkg::REG_POS_KI_UP:   cfg_reg.ki_up      <= cfg_data;
                cpc_pkg::REG_POS_KI_DOWN: cfg_reg.ki_down    <= cfg_data;
                cpc_pkg::REG_POS_KD:      cfg_reg.kd         <= cfg_data;
                cpc_pkg::REG_UP_LIMIT:    cfg_reg.up_limit   <= cfg_data[cpc_pkg::LIMIT_W-1:0];
                cpc_pkg::REG_DOWN_LIMIT:  cfg_reg.down_limit <= cfg_data[cpc_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    cpc_outer #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_outer (
        .clk            (clk),
        .rst_n          (rst_n),
        .step_en        (outer_en),
        .position_error (item_reg.position_error),
        .direction      (item_reg.direction),
        .cfg            (cfg_reg),
        .setpoint       (current_setpoint),
        .cur_kp         (cur_kp),
        .cur_ki         (cur_ki)
    );

    cpc_inner #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_inner (
        .clk              (clk),
        .rst_n            (rst_n),
        .step_en          (inner_en),
        .measured_current (item_reg.measured_current),
        .setpoint         (current_setpoint),
        .cur_kp           (cur_kp),
        .cur_ki           (cur_ki),
        .duty             (duty)
    );

    assign out_valid = out_vld_reg;

    // inner step always leaves duty inside 1..127
    a_duty_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        inner_en |=> (duty != '0))
        else $error("duty zero after inner step");

    // inner step leaves the setpoint alone
    a_inner_keeps_sp: assert property (@(posedge clk) disable iff (!rst_n)
        inner_en |=> $stable(current_setpoint))
        else $error("setpoint moved on inner step");

    // outer step leaves the duty alone
    a_outer_keeps_duty: assert property (@(posedge clk) disable iff (!rst_n)
        outer_en |=> $stable(duty))
        else $error("duty moved on outer step");

    // setpoint never exceeds the limit for the direction taken
    a_sp_limit: assert property (@(posedge clk) disable iff (!rst_n)
        outer_en |=> (current_setpoint <= ($past(item_reg.direction) ?
            $past(cfg_reg.up_limit) : $past(cfg_reg.down_limit))))
        else $error("setpoint above limit");

endmodule

FILE: sv/cpc_outer.sv
// Outer position loop: incremental PID, setpoint clamp and inner gain scheduling.
module cpc_outer #(
    parameter int GAIN_FRAC_BITS = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step_en,
    input  logic signed [cpc_pkg::ERR_W-1:0]    position_error,
    input  logic                                direction,
    input  cpc_pkg::pos_cfg_t                   cfg,
    output logic [cpc_pkg::SP_W-1:0]            setpoint,
    output logic [GAIN_FRAC_BITS+3:0]           cur_kp,
    output logic [GAIN_FRAC_BITS+3:0]           cur_ki
);

    localparam int F     = GAIN_FRAC_BITS;
    localparam int CG_W  = F + 4;
    localparam int ACC_W = F + 10;
    localparam int SUM_W = cpc_pkg::POS_SUM_W;
    localparam int T_W   = SUM_W - F;
    localparam int KE_W  = cpc_pkg::GAIN_W + 2;
    localparam int PE_W  = KE_W + 1 + cpc_pkg::ERR_W;
    localparam int PO_W  = cpc_pkg::GAIN_W + 1 + cpc_pkg::ERR_W;

    localparam logic [CG_W-1:0] KP_A = CG_W'(((64'(9) << F) + 64'(10)) / 64'(20));
    localparam logic [CG_W-1:0] KI_A = CG_W'(((64'(3) << F) + 64'(1)) / 64'(2));
    localparam logic [CG_W-1:0] KP_B = CG_W'(((64'(3) << F) + 64'(400)) / 64'(800));
    localparam logic [CG_W-1:0] KI_B = CG_W'(((64'(1) << F) + 64'(40)) / 64'(80));
    localparam logic [CG_W-1:0] KP_C = CG_W'(((64'(3) << F) + 64'(2000)) / 64'(4000));
    localparam logic [CG_W-1:0] KI_C = CG_W'(((64'(27) << F) + 64'(5000)) / 64'(10000));
    localparam logic [CG_W-1:0] KP_D = CG_W'(((64'(9) << F) + 64'(10000)) / 64'(20000));
    localparam logic [CG_W-1:0] KI_D = CG_W'(((64'(3) << F) + 64'(1000)) / 64'(2000));

    localparam logic signed [T_W-1:0] BAND_A = T_W'(cpc_pkg::SP_BAND_A);
    localparam logic signed [T_W-1:0] BAND_B = T_W'(cpc_pkg::SP_BAND_B);
    localparam logic signed [T_W-1:0] BAND_C = T_W'(cpc_pkg::SP_BAND_C);
    localparam logic signed [T_W-1:0] BAND_D = T_W'(cpc_pkg::SP_BAND_D);

    logic signed [cpc_pkg::ERR_W-1:0] prev_err_reg, older_err_reg;
    logic signed [ACC_W-1:0]          acc_reg, acc_next;
    logic [cpc_pkg::SP_W-1:0]         sp_reg, sp_next;
    logic [CG_W-1:0]                  kp_reg, kp_next, ki_reg, ki_next;

    logic [cpc_pkg::GAIN_W-1:0]   ki_sel;
    logic [cpc_pkg::LIMIT_W-1:0]  lim;
    logic signed [KE_W:0]         k_e_s, k_p_s;
    logic signed [cpc_pkg::GAIN_W:0] k_o_s;
    logic signed [PE_W-1:0]       prod_e, prod_p;
    logic signed [PO_W-1:0]       prod_o;
    logic signed [SUM_W-1:0]      sum, acc_clip;
    logic signed [T_W-1:0]        t_floor, t_trunc, t_clip, lim_s;

    assign ki_sel = direction ? cfg.ki_up : cfg.ki_down;
    assign lim    = direction ? cfg.up_limit : cfg.down_limit;

    assign k_e_s = {1'b0, KE_W'(cfg.kp) + KE_W'(ki_sel) + KE_W'(cfg.kd)};
    assign k_p_s = {1'b0, KE_W'(cfg.kp) + KE_W'({cfg.kd, 1'b0})};
    assign k_o_s = {1'b0, cfg.kd};

    assign prod_e = k_e_s * position_error;
    assign prod_p = k_p_s * prev_err_reg;
    assign prod_o = k_o_s * older_err_reg;

    assign sum = SUM_W'(acc_reg) + SUM_W'(prod_e) - SUM_W'(prod_p) + SUM_W'(prod_o);

    // truncate toward zero
    assign t_floor = T_W'(sum >>> F);
    assign t_trunc = t_floor + T_W'(sum[SUM_W-1] & (|sum[F-1:0]));
    assign lim_s   = T_W'(lim);

    always_comb
    begin
        t_clip   = t_trunc;
        acc_clip = sum;
        if (t_trunc > lim_s)
        begin
            t_clip   = lim_s;
            acc_clip = SUM_W'(lim) << F;
        end
        kp_next = kp_reg;
        ki_next = ki_reg;
        if (direction)
        begin
            if (t_clip < BAND_A)
            begin
                kp_next = KP_A;
                ki_next = KI_A;
            end
            else if (t_clip < BAND_B)
            begin
                kp_next = KP_B;
                ki_next = KI_B;
            end
            else if (t_clip < BAND_C)
            begin
                kp_next = KP_C;
                ki_next = KI_C;
            end
            else if (t_clip < BAND_D)
            begin
                kp_next = KP_D;
                ki_next = KI_D;
            end
        end
        else
        begin
            kp_next = KP_B;
            ki_next = KI_B;
        end
        sp_next  = t_clip[cpc_pkg::SP_W-1:0];
        acc_next = ACC_W'(acc_clip);
        if (t_clip[T_W-1])
        begin
            sp_next  = '0;
            acc_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg  <= '0;
            older_err_reg <= '0;
            acc_reg       <= '0;
            sp_reg        <= '0;
            kp_reg        <= KP_D;
            ki_reg        <= KI_D;
        end
        else if (step_en)
        begin
            prev_err_reg  <= position_error;
            older_err_reg <= prev_err_reg;
            acc_reg       <= acc_next;
            sp_reg        <= sp_next;
            kp_reg        <= kp_next;
            ki_reg        <= ki_next;
        end
    end

    assign setpoint = sp_reg;
    assign cur_kp   = kp_reg;
    assign cur_ki   = ki_reg;

endmodule

FILE: sv/cpc_inner.sv
// Inner current loop: incremental PI with duty saturation.
module cpc_inner #(
    parameter int GAIN_FRAC_BITS = 20
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             step_en,
    input  logic [cpc_pkg::MEAS_W-1:0]       measured_current,
    input  logic [cpc_pkg::SP_W-1:0]         setpoint,
    input  logic [GAIN_FRAC_BITS+3:0]        cur_kp,
    input  logic [GAIN_FRAC_BITS+3:0]        cur_ki,
    output logic [cpc_pkg::DUTY_W-1:0]       duty
);

    localparam int F      = GAIN_FRAC_BITS;
    localparam int CG_W   = F + 4;
    localparam int DACC_W = F + cpc_pkg::DUTY_W + 1;
    localparam int DSUM_W = F + 16;
    localparam int T_W    = DSUM_W - F;
    localparam int P1_W   = CG_W + 2 + cpc_pkg::ERR_W;
    localparam int P2_W   = CG_W + 1 + cpc_pkg::ERR_W;

    localparam logic signed [T_W-1:0] T_MAX = T_W'(cpc_pkg::DUTY_MAX);
    localparam logic signed [T_W-1:0] T_MIN = T_W'(cpc_pkg::DUTY_MIN);

    logic signed [cpc_pkg::ERR_W-1:0] prev_err_reg;
    logic signed [cpc_pkg::ERR_W-1:0] err;
    logic [DACC_W-1:0]                dacc_reg, dacc_next;
    logic signed [CG_W+1:0]           k_e_s;
    logic signed [CG_W:0]             k_p_s;
    logic signed [P1_W-1:0]           prod_e;
    logic signed [P2_W-1:0]           prod_p;
    logic signed [DSUM_W-1:0]         sum;
    logic signed [T_W-1:0]            t_floor, t_trunc;

    assign err   = {1'b0, setpoint} - {1'b0, measured_current};
    assign k_e_s = {1'b0, (CG_W+1)'(cur_kp) + (CG_W+1)'(cur_ki)};
    assign k_p_s = {1'b0, cur_kp};

    assign prod_e = k_e_s * err;
    assign prod_p = k_p_s * prev_err_reg;

    assign sum = DSUM_W'(dacc_reg) + DSUM_W'(prod_e) - DSUM_W'(prod_p);

    assign t_floor = T_W'(sum >>> F);
    assign t_trunc = t_floor + T_W'(sum[DSUM_W-1] & (|sum[F-1:0]));

    always_comb
    begin
        dacc_next = DACC_W'(sum);
        if (t_trunc > T_MAX)
            dacc_next = DACC_W'(cpc_pkg::DUTY_MAX) << F;
        else if (t_trunc < T_MIN)
            dacc_next = DACC_W'(cpc_pkg::DUTY_MIN) << F;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg <= '0;
            dacc_reg     <= '0;
        end
        else if (step_en)
        begin
            prev_err_reg <= err;
            dacc_reg     <= dacc_next;
        end
    end

    assign duty = dacc_reg[F+cpc_pkg::DUTY_W-1:F];

endmodule

FILE: test/cascaded_position_current_pid_test.sv
// Testbench for the cascaded position/current controller: directed and random beats checked against a predictor.
`timescale 1ns / 100ps

module cascaded_position_current_pid_test;

    localparam int FRAC          = 20;
    localparam int LATENCY       = 2;
    localparam int PHASES        = 8;
    localparam int PHASE_BEATS   = 165;
    localparam int QUIET_LIMIT   = 2000;
    localparam int MAX_REPORTS   = 20;
    localparam logic DIR_UP      = 1'b1;
    localparam logic DIR_DOWN    = 1'b0;
    localparam logic [cpc_pkg::CFG_IDX_W-1:0] REG_NONE_LO = 3'd6;
    localparam logic [cpc_pkg::CFG_IDX_W-1:0] REG_NONE_HI = 3'd7;

    typedef struct packed {
        logic [cpc_pkg::SP_W-1:0]   setpoint;
        logic [cpc_pkg::DUTY_W-1:0] duty;
    } result_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 in_valid = 1'b0;
    logic                                 in_stall;
    logic                                 opcode = cpc_pkg::OP_OUTER;
    logic signed [cpc_pkg::ERR_W-1:0]     position_error = '0;
    logic                                 direction = DIR_DOWN;
    logic [cpc_pkg::MEAS_W-1:0]           measured_current = '0;
    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    logic [cpc_pkg::SP_W-1:0]             current_setpoint;
    logic [cpc_pkg::DUTY_W-1:0]           duty;
    logic                                 cfg_we = 1'b0;
    logic [cpc_pkg::CFG_IDX_W-1:0]        cfg_index = '0;
    logic [cpc_pkg::GAIN_W-1:0]           cfg_data = '0;

    cpc_pkg::item_t beat_q[$];
    cpc_pkg::item_t held;
    result_t        expected_q[$];
    int             beats_queued = 0;
    int             results_seen = 0;
    int             fail_count = 0;
    int             gap_left = 0;
    int             stall_left = 0;
    int             quiet = 0;
    logic           sender_idle = 1'b1;
    logic           receiver_idle = 1'b1;

    // controller mirror
    cpc_pkg::pos_cfg_t                  ctl_cfg;
    logic signed [cpc_pkg::ERR_W:0]     err_d1, err_d2, cur_err_d1;
    logic signed [35:0]                 pos_acc, duty_acc;
    logic [cpc_pkg::SP_W-1:0]           sp_q;
    logic [cpc_pkg::GAIN_W-1:0]         ckp, cki;

    cascaded_position_current_pid #(.GAIN_FRAC_BITS(FRAC)) u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .opcode           (opcode),
        .position_error   (position_error),
        .direction        (direction),
        .measured_current (measured_current),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .current_setpoint (current_setpoint),
        .duty             (duty),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [cpc_pkg::GAIN_W-1:0] q_gain(longint n, longint d);
        return (cpc_pkg::GAIN_W)'(((n << FRAC) + d / 2) / d);
    endfunction

    function automatic longint whole_part(longint v);
        return (v >= 0) ? (v >>> FRAC) : -((-v) >>> FRAC);
    endfunction

    task automatic clear_model();
        ctl_cfg.kp         = q_gain(1, 5);
        ctl_cfg.ki_up      = q_gain(1, 1);
        ctl_cfg.ki_down    = q_gain(1, 100);
        ctl_cfg.kd         = q_gain(133, 5000);
        ctl_cfg.up_limit   = cpc_pkg::UP_LIMIT_RST;
        ctl_cfg.down_limit = cpc_pkg::DOWN_LIMIT_RST;
        err_d1     = '0;
        err_d2     = '0;
        cur_err_d1 = '0;
        pos_acc    = '0;
        duty_acc   = '0;
        sp_q       = '0;
        ckp        = q_gain(9, 20000);
        cki        = q_gain(3, 2000);
    endtask

    task automatic step_controller(cpc_pkg::item_t it);
        longint kp, ki, kd, lim, acc, t, e, p, o;
        result_t r;
        if (it.opcode == cpc_pkg::OP_OUTER)
        begin
            kp  = longint'(ctl_cfg.kp);
            kd  = longint'(ctl_cfg.kd);
            ki  = it.direction ? longint'(ctl_cfg.ki_up) : longint'(ctl_cfg.ki_down);
            lim = it.direction ? longint'(ctl_cfg.up_limit) : longint'(ctl_cfg.down_limit);
            e   = longint'(it.position_error);
            p   = longint'(err_d1);
            o   = longint'(err_d2);
            acc = longint'(pos_acc) + (kp + ki + kd) * e - (kp + 2 * kd) * p + kd * o;
            t   = whole_part(acc);
            if (t > lim)
            begin
                t   = lim;
                acc = lim <<< FRAC;
            end
            if (it.direction == DIR_UP)
            begin
                if (t < cpc_pkg::SP_BAND_A)
                begin
                    ckp = q_gain(9, 20);
                    cki = q_gain(3, 2);
                end
                else if (t < cpc_pkg::SP_BAND_B)
                begin
                    ckp = q_gain(3, 800);
                    cki = q_gain(1, 80);
                end
                else if (t < cpc_pkg::SP_BAND_C)
                begin
                    ckp = q_gain(3, 4000);
                    cki = q_gain(27, 10000);
                end
                else if (t < cpc_pkg::SP_BAND_D)
                begin
                    ckp = q_gain(9, 20000);
                    cki = q_gain(3, 2000);
                end
            end
            else
            begin
                ckp = q_gain(3, 800);
                cki = q_gain(1, 80);
            end
            if (t < 0)
            begin
                t   = 0;
                acc = 0;
            end
            pos_acc = 36'(acc);
            sp_q    = t[cpc_pkg::SP_W-1:0];
            err_d2  = err_d1;
            err_d1  = (cpc_pkg::ERR_W + 1)'(e);
        end
        else
        begin
            kp  = longint'(ckp);
            ki  = longint'(cki);
            e   = longint'(sp_q) - longint'(it.measured_current);
            p   = longint'(cur_err_d1);
            acc = longint'(duty_acc) + (kp + ki) * e - kp * p;
            t   = whole_part(acc);
            if (t > cpc_pkg::DUTY_MAX)
                acc = longint'(cpc_pkg::DUTY_MAX) <<< FRAC;
            else if (t < cpc_pkg::DUTY_MIN)
                acc = longint'(cpc_pkg::DUTY_MIN) <<< FRAC;
            duty_acc   = 36'(acc);
            cur_err_d1 = (cpc_pkg::ERR_W + 1)'(e);
        end
        r.setpoint = sp_q;
        t          = whole_part(longint'(duty_acc));
        r.duty     = t[cpc_pkg::DUTY_W-1:0];
        expected_q.push_back(r);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        if (fail_count < MAX_REPORTS)
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     results_seen, what, got, want);
        fail_count++;
    endtask

    task automatic push_beat(logic op, int err, logic dir, logic [cpc_pkg::MEAS_W-1:0] meas);
        cpc_pkg::item_t it;
        it.opcode           = op;
        it.position_error   = (cpc_pkg::ERR_W)'(err);
        it.direction        = dir;
        it.measured_current = meas;
        beat_q.push_back(it);
        beats_queued++;
    endtask

    task automatic set_reg(logic [cpc_pkg::CFG_IDX_W-1:0] idx,
                           logic [cpc_pkg::GAIN_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            cpc_pkg::REG_POS_KP:      ctl_cfg.kp         = data;
            cpc_pkg::REG_POS_KI_UP:   ctl_cfg.ki_up      = data;
            cpc_pkg::REG_POS_KI_DOWN: ctl_cfg.ki_down    = data;
            cpc_pkg::REG_POS_KD:      ctl_cfg.kd         = data;
            cpc_pkg::REG_UP_LIMIT:    ctl_cfg.up_limit   = data[cpc_pkg::LIMIT_W-1:0];
            cpc_pkg::REG_DOWN_LIMIT:  ctl_cfg.down_limit = data[cpc_pkg::LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (results_seen != beats_queued)
            @(posedge clk);
    endtask

    function automatic logic [cpc_pkg::GAIN_W-1:0] rand_gain();
        return (cpc_pkg::GAIN_W)'(($urandom_range(0, 3) == 0) ?
                                  $urandom : $urandom_range(0, 24'h3FFFFF));
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                step_controller(held);
            if (in_valid && in_stall)
                ;
            else if (gap_left != 0)
            begin
                in_valid <= 1'b0;
                gap_left--;
            end
            else if (beat_q.size() != 0)
            begin
                held = beat_q.pop_front();
                opcode           <= held.opcode;
                position_error   <= held.position_error;
                direction        <= held.direction;
                measured_current <= held.measured_current;
                in_valid         <= 1'b1;
                gap_left = sender_idle ? $urandom_range(0, 7) : 0;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("unexpected result beat", int'(current_setpoint), 0);
                else
                begin
                    want = expected_q.pop_front();
                    if (current_setpoint !== want.setpoint)
                        report_mismatch("current_setpoint", int'(current_setpoint),
                                        int'(want.setpoint));
                    if (duty !== want.duty)
                        report_mismatch("duty", int'(duty), int'(want.duty));
                end
                results_seen++;
                stall_left = receiver_idle ? $urandom_range(0, 7) : 0;
            end
            if (stall_left != 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet <= 0;
            else if (quiet == QUIET_LIMIT)
            begin
                $display("FAIL cascaded_position_current_pid");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    initial
    begin
        int ph, k, len, e0, target;
        logic dir;
        clear_model();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // ignored indexes, and a limit write with junk above the low byte
        set_reg(REG_NONE_LO, (cpc_pkg::GAIN_W)'($urandom));
        set_reg(REG_NONE_HI, (cpc_pkg::GAIN_W)'($urandom));
        set_reg(cpc_pkg::REG_UP_LIMIT, 24'hA5A596);

        // small negative action stays as a fraction
        push_beat(cpc_pkg::OP_OUTER, -1, DIR_DOWN, 8'hFF);
        push_beat(cpc_pkg::OP_OUTER, -1, DIR_DOWN, 8'h00);
        push_beat(cpc_pkg::OP_INNER, 255, DIR_UP, 8'h00);
        // clamp at the up limit, setpoint above the top band
        push_beat(cpc_pkg::OP_OUTER, 255, DIR_UP, 8'h00);
        push_beat(cpc_pkg::OP_INNER, 0, DIR_DOWN, 8'h00);
        push_beat(cpc_pkg::OP_INNER, 0, DIR_DOWN, 8'hFF);
        push_beat(cpc_pkg::OP_OUTER, 255, DIR_UP, 8'h55);
        push_beat(cpc_pkg::OP_OUTER, -256, DIR_UP, 8'hAA);
        push_beat(cpc_pkg::OP_OUTER, 0, DIR_UP, 8'h00);
        push_beat(cpc_pkg::OP_OUTER, 35, DIR_UP, 8'h00);
        push_beat(cpc_pkg::OP_INNER, -256, DIR_DOWN, 8'h55);
        push_beat(cpc_pkg::OP_INNER, 170, DIR_UP, 8'hAA);
        push_beat(cpc_pkg::OP_OUTER, 255, DIR_DOWN, 8'h00);
        push_beat(cpc_pkg::OP_INNER, 0, DIR_DOWN, 8'h00);
        push_beat(cpc_pkg::OP_OUTER, -255, DIR_DOWN, 8'h00);
        push_beat(cpc_pkg::OP_INNER, 0, DIR_UP, 8'h80);

        for (ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            if (ph == 1 || ph == 2)
            begin
                set_reg(cpc_pkg::REG_POS_KP, (ph == 1) ? '0 : '1);
                set_reg(cpc_pkg::REG_POS_KI_UP, (ph == 1) ? '0 : '1);
                set_reg(cpc_pkg::REG_POS_KI_DOWN, (ph == 1) ? '0 : '1);
                set_reg(cpc_pkg::REG_POS_KD, (ph == 1) ? '0 : '1);
                set_reg(cpc_pkg::REG_UP_LIMIT, (ph == 1) ? 24'hFFFF00 : 24'h0000FF);
                set_reg(cpc_pkg::REG_DOWN_LIMIT, (ph == 1) ? 24'h000000 : 24'h0000FF);
            end
            else if (ph > 2)
            begin
                set_reg(cpc_pkg::REG_POS_KP, rand_gain());
                set_reg(cpc_pkg::REG_POS_KI_UP, rand_gain());
                set_reg(cpc_pkg::REG_POS_KI_DOWN, rand_gain());
                set_reg(cpc_pkg::REG_POS_KD, rand_gain());
                set_reg(cpc_pkg::REG_UP_LIMIT, {16'($urandom_range(0, 16'hFFFF)),
                        8'((ph % 2) ? $urandom_range(100, 255) : $urandom_range(0, 255))});
                set_reg(cpc_pkg::REG_DOWN_LIMIT, {16'($urandom_range(0, 16'hFFFF)),
                        8'($urandom_range(0, 255))});
                set_reg(ph[0] ? REG_NONE_LO : REG_NONE_HI, (cpc_pkg::GAIN_W)'($urandom));
            end
            sender_idle   = (ph % 4) != 2;
            receiver_idle = (ph % 4) != 3;

            target = beats_queued + PHASE_BEATS;
            while (beats_queued < target)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    // approach move: one direction, error shrinking, current loop in between
                    dir = 1'($urandom_range(0, 1));
                    e0  = $urandom_range(0, 510);
                    e0  = e0 - 255;
                    len = $urandom_range(3, 10);
                    for (k = 0; k < len; k++)
                    begin
                        push_beat(cpc_pkg::OP_OUTER, e0 - (e0 * k) / len, dir, 8'($urandom));
                        repeat ($urandom_range(1, 3))
                            push_beat(cpc_pkg::OP_INNER, $urandom, 1'($urandom),
                                      8'($urandom_range(0, 80)));
                    end
                end
                else
                    push_beat(1'($urandom), $urandom, 1'($urandom), 8'($urandom));
            end
        end

        wait_idle();
        repeat (LATENCY + 4) @(posedge clk);
        if (expected_q.size() != 0)
            report_mismatch("results never delivered", expected_q.size(), 0);
        if (fail_count == 0)
            $display("PASS cascaded_position_current_pid");
        else
            $display("FAIL cascaded_position_current_pid");
        $finish;
    end

endmodule

FILE: filelist.f
sv/cpc_pkg.sv
sv/cpc_outer.sv
sv/cpc_inner.sv
sv/cascaded_position_current_pid.sv
test/cascaded_position_current_pid_test.sv
